### rtl/core/mdtg_pkg.sv
// ----------------------------------------------------------------------------
// mdtg_pkg
// Shared types and constants of the MD tag token generator.
// ----------------------------------------------------------------------------
package mdtg_pkg;

	localparam int KIND_BITS   = 3;
	localparam int RUN_BITS    = 16;
	localparam int SYM_BITS    = 8;
	localparam int MAX_TOK     = 3;
	localparam int NTOK_BITS   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = QPTR_BITS + 1;

	localparam logic [SYM_BITS-1:0] GAP_RESET = 8'd45;
	localparam logic [RUN_BITS-1:0] RUN_MAX   = {RUN_BITS{1'b1}};

	// Token kinds.
	localparam logic [KIND_BITS-1:0] KIND_MISMATCH = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_CARET    = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_DELETED  = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_END      = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_ERROR    = 3'd4;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [RUN_BITS-1:0]  run;
		logic [SYM_BITS-1:0]  sym;
	} tok_t;

	// All tokens caused by one column, oldest in slot zero.
	typedef struct packed {
		logic [NTOK_BITS-1:0]     ntok;
		tok_t [MAX_TOK-1:0]       tok;
	} bundle_t;

	// Write side of the column queue.
	typedef struct packed {
		logic    valid;
		bundle_t data;
	} qwr_t;

	// Read side of the column queue.
	typedef struct packed {
		logic    empty;
		bundle_t head;
	} qrd_t;

endpackage

### rtl/core/mdtg_front.sv
// ----------------------------------------------------------------------------
// mdtg_front
// Classifies each column, keeps the match count and deletion state, and
// writes the tokens of the column as one bundle into the column queue.
// ----------------------------------------------------------------------------
module mdtg_front #(
	parameter int COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mdtg_pkg::SYM_BITS-1:0] cfg_wdata,
	input  logic                         accept,
	input  logic [mdtg_pkg::SYM_BITS-1:0] query_symbol,
	input  logic [mdtg_pkg::SYM_BITS-1:0] subject_symbol,
	input  logic                         final_column,
	output mdtg_pkg::qwr_t               qwr
);

	logic [mdtg_pkg::SYM_BITS-1:0] gap_q;
	logic [COUNT_BITS-1:0]         cnt_q;
	logic                          del_q;
	logic [COUNT_BITS-1:0]         cnt_col;
	logic [COUNT_BITS-1:0]         cnt_d;
	logic                          del_d;
	logic                          qg;
	logic                          sg;
	logic [mdtg_pkg::RUN_BITS-1:0] run_now;
	logic [mdtg_pkg::RUN_BITS-1:0] run_col;
	logic [mdtg_pkg::NTOK_BITS-1:0] n;
	mdtg_pkg::bundle_t             bnd;

	assign qg = (query_symbol == gap_q);
	assign sg = (subject_symbol == gap_q);

	// The reported run is the counter capped at the token field's maximum.
	if (COUNT_BITS > mdtg_pkg::RUN_BITS) begin : g_cap
		assign run_now = (|cnt_q[COUNT_BITS-1:mdtg_pkg::RUN_BITS]) ? mdtg_pkg::RUN_MAX :
			cnt_q[mdtg_pkg::RUN_BITS-1:0];
		assign run_col = (|cnt_col[COUNT_BITS-1:mdtg_pkg::RUN_BITS]) ? mdtg_pkg::RUN_MAX :
			cnt_col[mdtg_pkg::RUN_BITS-1:0];
	end else begin : g_ext
		assign run_now = mdtg_pkg::RUN_BITS'(cnt_q);
		assign run_col = mdtg_pkg::RUN_BITS'(cnt_col);
	end

	// Next count and deletion state from the column class.
	always_comb begin
		cnt_col = cnt_q;
		del_d   = del_q;
		if (qg && sg) begin
			cnt_col = cnt_q;
		end else if (sg) begin
			del_d = 1'b0;
		end else if (qg) begin
			if (!del_q) begin
				cnt_col = '0;
				del_d   = 1'b1;
			end
		end else begin
			del_d = 1'b0;
			if (query_symbol != subject_symbol) begin
				cnt_col = '0;
			end else if (cnt_q != {COUNT_BITS{1'b1}}) begin
				cnt_col = cnt_q + 1'b1;
			end
		end
		cnt_d = cnt_col;
		if (final_column) begin
			cnt_d = '0;
			del_d = 1'b0;
		end
	end

	// Token bundle of the column, filled in emission order.
	always_comb begin
		bnd = '0;
		n   = '0;
		if (qg && sg) begin
			bnd.tok[n].kind = mdtg_pkg::KIND_ERROR;
			n = n + 1'b1;
		end else if (sg) begin
			n = n;
		end else if (qg) begin
			if (!del_q) begin
				bnd.tok[n].kind = mdtg_pkg::KIND_CARET;
				bnd.tok[n].run  = run_now;
				n = n + 1'b1;
			end
			bnd.tok[n].kind = mdtg_pkg::KIND_DELETED;
			bnd.tok[n].sym  = subject_symbol;
			n = n + 1'b1;
		end else if (query_symbol != subject_symbol) begin
			bnd.tok[n].kind = mdtg_pkg::KIND_MISMATCH;
			bnd.tok[n].run  = run_now;
			bnd.tok[n].sym  = subject_symbol;
			n = n + 1'b1;
		end
		if (final_column) begin
			bnd.tok[n].kind = mdtg_pkg::KIND_END;
			bnd.tok[n].run  = run_col;
			n = n + 1'b1;
		end
		bnd.ntok = n;
	end

	assign qwr.valid = accept && (n != '0);
	assign qwr.data  = bnd;

	// Gap code register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= mdtg_pkg::GAP_RESET;
		end else if (cfg_we) begin
			gap_q <= cfg_wdata;
		end
	end

	// Column state, updated on every accepted column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			del_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= cnt_d;
			del_q <= del_d;
		end
	end

endmodule

### rtl/core/mdtg_queue.sv
// ----------------------------------------------------------------------------
// mdtg_queue
// Short queue of token bundles between the classifier and the token sender.
// ----------------------------------------------------------------------------
module mdtg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  mdtg_pkg::qwr_t qwr,
	input  logic           deq,
	output logic           full,
	output mdtg_pkg::qrd_t qrd
);

	mdtg_pkg::bundle_t                 mem_q [mdtg_pkg::QUEUE_DEPTH];
	logic [mdtg_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [mdtg_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [mdtg_pkg::QCNT_BITS-1:0]    count_q;
	logic                              do_deq;

	assign full      = (count_q == mdtg_pkg::QCNT_BITS'(mdtg_pkg::QUEUE_DEPTH));
	assign qrd.empty = (count_q == '0);
	assign qrd.head  = mem_q[rd_ptr_q];
	assign do_deq    = deq && !qrd.empty;

	// Bundle storage.
	always_ff @(posedge clk) begin
		if (qwr.valid) begin
			mem_q[wr_ptr_q] <= qwr.data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qwr.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({qwr.valid, do_deq})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/mdtg_back.sv
// ----------------------------------------------------------------------------
// mdtg_back
// Sends the tokens of the head bundle one transfer at a time and releases
// the bundle after its last token.
// ----------------------------------------------------------------------------
module mdtg_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mdtg_pkg::qrd_t                 qrd,
	input  logic                           pop,
	output logic                           deq,
	output logic                           empty,
	output logic [mdtg_pkg::KIND_BITS-1:0] token_kind,
	output logic [mdtg_pkg::RUN_BITS-1:0]  match_run,
	output logic [mdtg_pkg::SYM_BITS-1:0]  symbol_out,
	output logic                           column_done,
	output logic                           record_done
);

	logic [mdtg_pkg::NTOK_BITS-1:0] idx_q;
	mdtg_pkg::tok_t                 cur;
	logic                           last_tok;
	logic                           xfer;

	assign cur         = qrd.head.tok[idx_q];
	assign last_tok    = (idx_q == qrd.head.ntok - 1'b1);
	assign empty       = qrd.empty;
	assign xfer        = pop && !qrd.empty;
	assign deq         = xfer && last_tok;

	assign token_kind  = cur.kind;
	assign match_run   = cur.run;
	assign symbol_out  = cur.sym;
	assign column_done = last_tok;
	assign record_done = (cur.kind == mdtg_pkg::KIND_END);

	// Token index within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= last_tok ? '0 : idx_q + 1'b1;
		end
	end

endmodule

### rtl/core/md_tag_generator.sv
// ----------------------------------------------------------------------------
// md_tag_generator
// Turns an alignment, one column per transfer, into the tokens of an MD tag.
// ----------------------------------------------------------------------------
// Usage:
// Columns enter on the push/full side; a column is taken on any edge with
// push high and full low. Tokens leave on the empty/pop side; the oldest
// token is on the result ports while empty is low and is consumed on an edge
// with pop high. cfg_we writes the gap code from cfg_wdata at once.
// A column is classified in the cycle it is taken. Its tokens, up to three,
// travel as one bundle through a four-entry queue; into an empty queue, the
// first token shows in the cycle after the transfer. Columns are taken at one
// per cycle while the queue has room, and tokens leave at one per cycle while
// pop is high, so a column with k tokens holds its queue entry for k output
// transfers. Match and non-final insertion columns make no token and use no entry.
// When the receiver stalls, the queue fills and full rises after four
// waiting columns with tokens. Reset clears the count, the deletion flag and
// the queue, and sets the gap code to 45.
// ----------------------------------------------------------------------------
module md_tag_generator #(
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mdtg_pkg::SYM_BITS-1:0]  cfg_wdata,
	input  logic                           push,
	output logic                           full,
	input  logic [mdtg_pkg::SYM_BITS-1:0]  query_symbol,
	input  logic [mdtg_pkg::SYM_BITS-1:0]  subject_symbol,
	input  logic                           final_column,
	output logic                           empty,
	input  logic                           pop,
	output logic [mdtg_pkg::KIND_BITS-1:0] token_kind,
	output logic [mdtg_pkg::RUN_BITS-1:0]  match_run,
	output logic [mdtg_pkg::SYM_BITS-1:0]  symbol_out,
	output logic                           column_done,
	output logic                           record_done
);

	mdtg_pkg::qwr_t qwr;
	mdtg_pkg::qrd_t qrd;
	logic           accept;
	logic           deq;

	assign accept = push && !full;

	mdtg_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.query_symbol  (query_symbol),
		.subject_symbol(subject_symbol),
		.final_column  (final_column),
		.qwr           (qwr)
	);

	mdtg_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.qwr   (qwr),
		.deq   (deq),
		.full  (full),
		.qrd   (qrd)
	);

	mdtg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qrd        (qrd),
		.pop        (pop),
		.deq        (deq),
		.empty      (empty),
		.token_kind (token_kind),
		.match_run  (match_run),
		.symbol_out (symbol_out),
		.column_done(column_done),
		.record_done(record_done)
	);

endmodule

### rtl/core/mdtg_checker.sv
// ----------------------------------------------------------------------------
// mdtg_checker
// Port-level checks of the MD tag token generator, bound to the top level.
// ----------------------------------------------------------------------------
module mdtg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           push,
	input logic                           full,
	input logic                           empty,
	input logic                           pop,
	input logic [mdtg_pkg::KIND_BITS-1:0] token_kind,
	input logic [mdtg_pkg::RUN_BITS-1:0]  match_run,
	input logic [mdtg_pkg::SYM_BITS-1:0]  symbol_out,
	input logic                           column_done,
	input logic                           record_done
);

	// An end token closes its column and only an end token closes a record.
	a_record_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (record_done == (token_kind == mdtg_pkg::KIND_END)) &&
			(!record_done || column_done))
		else $error("record_done does not match an end token");

	// Deleted-base and error tokens carry no count.
	a_run_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (token_kind == mdtg_pkg::KIND_DELETED ||
			token_kind == mdtg_pkg::KIND_ERROR)) |-> (match_run == '0))
		else $error("count on a token kind that carries none");

	// Only mismatch and deleted-base tokens carry a symbol.
	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (token_kind == mdtg_pkg::KIND_CARET ||
			token_kind == mdtg_pkg::KIND_END ||
			token_kind == mdtg_pkg::KIND_ERROR)) |-> (symbol_out == '0))
		else $error("symbol on a token kind that carries none");

	// No token appears without a column transfer.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !(push && !full)) |=> empty)
		else $error("token appeared without an input transfer");

endmodule

bind md_tag_generator mdtg_checker u_mdtg_checker (.*);

### test/md_tag_checker.sv
// ----------------------------------------------------------------------------
// md_tag_checker
// Predicts the MD tag tokens of every column transfer and checks the outputs.
// ----------------------------------------------------------------------------
// The checker watches the configuration port, the column side and the token
// side of the generator. Each accepted column is classified against its own
// copy of the gap code, match count and deletion flag. The tokens it should
// cause are queued, and each token transfer is compared field by field with
// the oldest queued token.
// ----------------------------------------------------------------------------
module md_tag_checker #(
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mdtg_pkg::SYM_BITS-1:0]  cfg_wdata,
	input  logic                           push,
	input  logic                           full,
	input  logic [mdtg_pkg::SYM_BITS-1:0]  query_symbol,
	input  logic [mdtg_pkg::SYM_BITS-1:0]  subject_symbol,
	input  logic                           final_column,
	input  logic                           empty,
	input  logic                           pop,
	input  logic [mdtg_pkg::KIND_BITS-1:0] token_kind,
	input  logic [mdtg_pkg::RUN_BITS-1:0]  match_run,
	input  logic [mdtg_pkg::SYM_BITS-1:0]  symbol_out,
	input  logic                           column_done,
	input  logic                           record_done,
	output int                             errors,
	output int                             pending,
	output int                             tokens_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

	typedef struct {
		logic [mdtg_pkg::KIND_BITS-1:0] kind;
		logic [mdtg_pkg::RUN_BITS-1:0]  run;
		logic [mdtg_pkg::SYM_BITS-1:0]  sym;
		logic                           col_done;
		logic                           rec_done;
	} md_token_t;

	md_token_t                     expected_tokens[$];
	logic [mdtg_pkg::SYM_BITS-1:0] gap_symbol;
	logic [COUNT_BITS-1:0]         match_total;
	logic                          open_deletion;
	int                            mismatch_count = 0;
	int                            tokens_seen = 0;

	// The emitted count is the internal count capped to the output width.
	function automatic logic [mdtg_pkg::RUN_BITS-1:0] capped_run(
			input logic [COUNT_BITS-1:0] count);
		logic [63:0] wide;
		wide = 64'(count);
		return (wide > 64'(mdtg_pkg::RUN_MAX)) ? mdtg_pkg::RUN_MAX :
			wide[mdtg_pkg::RUN_BITS-1:0];
	endfunction

	task automatic add_token(input logic [mdtg_pkg::KIND_BITS-1:0] kind,
			input logic [mdtg_pkg::RUN_BITS-1:0] run,
			input logic [mdtg_pkg::SYM_BITS-1:0] sym, input logic rec);
		md_token_t tok;
		tok.kind = kind;
		tok.run = run;
		tok.sym = sym;
		tok.col_done = 1'b0;
		tok.rec_done = rec;
		expected_tokens.push_back(tok);
	endtask

	// Classify one column and queue the tokens it causes.
	task automatic predict_column(input logic [mdtg_pkg::SYM_BITS-1:0] q,
			input logic [mdtg_pkg::SYM_BITS-1:0] s, input logic is_last);
		int   depth_before;
		logic q_gap;
		logic s_gap;
		depth_before = expected_tokens.size();
		q_gap = (q == gap_symbol);
		s_gap = (s == gap_symbol);
		if (q_gap && s_gap) begin
			// A gap on both rows is an error and leaves the state alone.
			add_token(mdtg_pkg::KIND_ERROR, '0, '0, 1'b0);
		end else if (s_gap) begin
			open_deletion = 1'b0;
		end else if (q_gap) begin
			if (!open_deletion) begin
				add_token(mdtg_pkg::KIND_CARET, capped_run(match_total), '0, 1'b0);
				match_total = '0;
				open_deletion = 1'b1;
			end
			add_token(mdtg_pkg::KIND_DELETED, '0, s, 1'b0);
		end else begin
			open_deletion = 1'b0;
			if (q != s) begin
				add_token(mdtg_pkg::KIND_MISMATCH, capped_run(match_total), s, 1'b0);
				match_total = '0;
			end else if (match_total != COUNT_TOP) begin
				match_total = match_total + 1'b1;
			end
		end
		if (is_last) begin
			add_token(mdtg_pkg::KIND_END, capped_run(match_total), '0, 1'b1);
			match_total = '0;
			open_deletion = 1'b0;
		end
		if (expected_tokens.size() > depth_before) begin
			expected_tokens[expected_tokens.size() - 1].col_done = 1'b1;
		end
	endtask

	// Compare one token transfer with the oldest expected token.
	task automatic check_token();
		md_token_t want;
		tokens_seen++;
		if (expected_tokens.size() == 0) begin
			if (mismatch_count < 10) begin
				$display("%0t: unexpected token kind %0d run %0d sym %02h col %0b rec %0b",
					$time, token_kind, match_run, symbol_out, column_done, record_done);
			end
			mismatch_count++;
		end else begin
			want = expected_tokens.pop_front();
			if (token_kind !== want.kind || match_run !== want.run || symbol_out !== want.sym ||
					column_done !== want.col_done || record_done !== want.rec_done) begin
				if (mismatch_count < 10) begin
					$display("%0t: token mismatch, expected kind %0d run %0d sym %02h col %0b rec %0b",
						$time, want.kind, want.run, want.sym, want.col_done, want.rec_done);
					$display("%0t:                 got kind %0d run %0d sym %02h col %0b rec %0b",
						$time, token_kind, match_run, symbol_out, column_done, record_done);
				end
				mismatch_count++;
			end
		end
	endtask

	// Track every transfer and configuration write at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_symbol = mdtg_pkg::GAP_RESET;
			match_total = '0;
			open_deletion = 1'b0;
			expected_tokens.delete();
		end else begin
			if (pop && !empty) begin
				check_token();
			end
			if (push && !full) begin
				predict_column(query_symbol, subject_symbol, final_column);
			end
			if (cfg_we) begin
				gap_symbol = cfg_wdata;
			end
		end
		errors <= mismatch_count;
		pending <= expected_tokens.size();
		tokens_checked <= tokens_seen;
	end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the MD tag token generator.
// ----------------------------------------------------------------------------
// Drives alignment columns into the generator and drains its tokens with
// random gaps on both sides. A directed run covers every column class and the
// end-of-alignment cases; random alignments follow under several gap codes,
// including both extremes. One phase stalls the token side long enough to fill
// the internal queue. All checking happens in md_tag_checker and the bound mdtg_checker.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_BITS  = 16;
	localparam int CYCLE_LIMIT = 60000;
	localparam int LONG_HOLD   = 300;
	localparam int PHASE_COLS  = 115;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [mdtg_pkg::SYM_BITS-1:0]  cfg_wdata = '0;
	logic                           push = 1'b0;
	logic                           full;
	logic [mdtg_pkg::SYM_BITS-1:0]  query_symbol = '0;
	logic [mdtg_pkg::SYM_BITS-1:0]  subject_symbol = '0;
	logic                           final_column = 1'b0;
	logic                           empty;
	logic                           pop = 1'b0;
	logic [mdtg_pkg::KIND_BITS-1:0] token_kind;
	logic [mdtg_pkg::RUN_BITS-1:0]  match_run;
	logic [mdtg_pkg::SYM_BITS-1:0]  symbol_out;
	logic                           column_done;
	logic                           record_done;

	int errors;
	int pending;
	int tokens_checked;

	bit                            tx_calm = 1'b0;
	bit                            rx_calm = 1'b0;
	bit                            hold_request = 1'b0;
	int                            columns_sent = 0;
	int                            cycle_count = 0;
	logic [mdtg_pkg::SYM_BITS-1:0] gap_now = mdtg_pkg::GAP_RESET;
	logic [mdtg_pkg::SYM_BITS-1:0] mid_gap;

	md_tag_generator #(
		.COUNT_BITS(COUNT_BITS)
	) i_dut (.*);

	md_tag_checker #(
		.COUNT_BITS(COUNT_BITS)
	) i_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case a transfer never completes.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Random symbol that differs from both arguments.
	function automatic logic [mdtg_pkg::SYM_BITS-1:0] any_but(
			input logic [mdtg_pkg::SYM_BITS-1:0] a, input logic [mdtg_pkg::SYM_BITS-1:0] b);
		logic [mdtg_pkg::SYM_BITS-1:0] v;
		do begin
			v = mdtg_pkg::SYM_BITS'($urandom_range(0, 255));
		end while (v == a || v == b);
		return v;
	endfunction

	// Offer one column after a random gap and hold it until the transfer.
	task automatic send_column(input logic [mdtg_pkg::SYM_BITS-1:0] q,
			input logic [mdtg_pkg::SYM_BITS-1:0] s, input logic is_last);
		int gap_cycles;
		gap_cycles = tx_calm ? 0 : $urandom_range(0, 3);
		if (gap_cycles > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap_cycles - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		query_symbol <= q;
		subject_symbol <= s;
		final_column <= is_last;
		do begin
			@(posedge clk);
		end while (full);
		columns_sent++;
	endtask

	// Stop offering and wait until every expected token has left.
	task automatic settle();
		@(negedge clk) push <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_gap(input logic [mdtg_pkg::SYM_BITS-1:0] code);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(negedge clk) cfg_we <= 1'b0;
		gap_now = code;
	endtask

	// One alignment of random length, ended by a final column unless the noise moves the flag.
	task automatic send_alignment();
		int                            ncol;
		int                            pick;
		int                            run_len;
		logic                          is_last;
		logic [mdtg_pkg::SYM_BITS-1:0] q;
		logic [mdtg_pkg::SYM_BITS-1:0] s;
		ncol = $urandom_range(1, 12);
		for (int c = 0; c < ncol; c++) begin
			pick = $urandom_range(0, 99);
			is_last = (c == ncol - 1);
			if (pick < 40) begin
				s = any_but(gap_now, gap_now);
				send_column(s, s, is_last);
			end else if (pick < 60) begin
				s = any_but(gap_now, gap_now);
				q = any_but(gap_now, s);
				send_column(q, s, is_last);
			end else if (pick < 75) begin
				run_len = $urandom_range(1, 4);
				for (int r = 0; r < run_len; r++) begin
					send_column(gap_now, any_but(gap_now, gap_now), is_last && r == run_len - 1);
				end
			end else if (pick < 87) begin
				send_column(any_but(gap_now, gap_now), gap_now, is_last);
			end else if (pick < 92) begin
				send_column(gap_now, gap_now, is_last);
			end else begin
				// Noise: any symbols, with the final flag anywhere.
				send_column(mdtg_pkg::SYM_BITS'($urandom_range(0, 255)),
					mdtg_pkg::SYM_BITS'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic random_phase(input int ncols);
		int start;
		start = columns_sent;
		while (columns_sent - start < ncols) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			send_alignment();
		end
		tx_calm = 1'b0;
	endtask

	// Token side: random stalls, calm stretches and one long hold-off on request.
	initial begin : token_drain
		int stall;
		int moved;
		bit held;
		moved = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !held) begin
				@(negedge clk) pop <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				held = 1'b1;
			end
			if (moved % 16 == 0) begin
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			stall = rx_calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				@(negedge clk) pop <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) pop <= 1'b1;
			do begin
				@(posedge clk);
			end while (empty);
			moved++;
		end
	end

	// Column side and verdict.
	initial begin : column_feed
		logic [mdtg_pkg::SYM_BITS-1:0] s;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed columns under the reset gap code.
		send_column(8'h00, 8'h00, 1'b0);
		send_column(8'hFF, 8'hFF, 1'b0);
		send_column(8'h00, 8'hFF, 1'b0);
		send_column(8'hFF, 8'h00, 1'b0);
		send_column(8'h41, 8'h41, 1'b0);
		// Deletion group opens with a caret, then deleted bases only.
		send_column(gap_now, 8'h41, 1'b0);
		send_column(gap_now, 8'hFF, 1'b0);
		// A double gap inside the group leaves it open.
		send_column(gap_now, gap_now, 1'b0);
		send_column(gap_now, 8'h00, 1'b0);
		// An insertion closes the group.
		send_column(8'h43, gap_now, 1'b0);
		send_column(gap_now, 8'h54, 1'b0);
		send_column(8'h47, 8'h47, 1'b0);
		// Final deletion column causes caret, deleted base and end token.
		send_column(gap_now, 8'h07, 1'b1);
		send_column(gap_now, 8'h07, 1'b0);
		send_column(8'h41, 8'h41, 1'b1);
		send_column(8'h41, gap_now, 1'b1);
		send_column(gap_now, gap_now, 1'b1);
		send_column(8'h43, 8'h43, 1'b0);
		send_column(8'h43, 8'h54, 1'b1);
		send_column(8'hAA, 8'h55, 1'b0);
		send_column(8'h55, 8'hAA, 1'b1);
		settle();

		// Random alignments with the gap code at its low extreme.
		write_gap(8'h00);
		random_phase(PHASE_COLS);
		settle();

		// High extreme, starting with a long token-side stall to fill the queue.
		write_gap(8'hFF);
		hold_request = 1'b1;
		repeat (40) begin
			s = any_but(gap_now, gap_now);
			send_column(any_but(gap_now, s), s, 1'b0);
		end
		send_column(gap_now, any_but(gap_now, gap_now), 1'b1);
		settle();
		random_phase(PHASE_COLS);
		settle();

		// Some gap code in between.
		mid_gap = mdtg_pkg::SYM_BITS'($urandom_range(1, 254));
		write_gap(mid_gap);
		random_phase(PHASE_COLS);
		settle();
		repeat (20) @(posedge clk);

		$display("summary: %0d columns under gap codes 45, 0, 255 and %0d; %0d tokens checked",
			columns_sent, mid_gap, tokens_checked);
		$display("summary: all column classes, final columns, a full-queue stall, idle drains");
		if (errors == 0 && pending == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
